[rtl/lr_pkg.sv]
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared widths, line modes, request codes and the setup record.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_W = 10;
    localparam int ERR_W   = 12;

    typedef enum logic [1:0] {
        MODE_VERT = 2'd0,
        MODE_HORZ = 2'd1,
        MODE_XMAJ = 2'd2,
        MODE_YMAJ = 2'd3
    } line_mode_t;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [ERR_W-1:0]   err_t;

    // inc_move is the error increment when the minor axis moves, inc_stay when
    // it holds; inc_stay carries the sign of the minor-axis difference.
    typedef struct packed {
        line_mode_t mode;
        coord_t     major;
        coord_t     minor;
        coord_t     limit;
        err_t       err;
        err_t       inc_move;
        err_t       inc_stay;
    } lr_line_t;

    typedef struct packed {
        logic     is_start;
        lr_line_t line;
    } lr_req_t;

endpackage

[rtl/lr_req_if.sv]
// ----------------------------------------------------------------------------
// Line request channel
// Valid/ready channel carrying a start or step request.
// ----------------------------------------------------------------------------
interface lr_req_if;
    logic              valid;
    logic              ready;
    logic              operation;
    lr_pkg::coord_t    x_start;
    lr_pkg::coord_t    y_start;
    lr_pkg::coord_t    x_end;
    lr_pkg::coord_t    y_end;

    modport source (output valid, operation, x_start, y_start, x_end, y_end,
                    input ready);
    modport sink   (input valid, operation, x_start, y_start, x_end, y_end,
                    output ready);
endinterface

[rtl/lr_pix_if.sv]
// ----------------------------------------------------------------------------
// Pixel result channel
// Valid/ready channel carrying one emitted pixel.
// ----------------------------------------------------------------------------
interface lr_pix_if;
    logic              valid;
    logic              ready;
    lr_pkg::coord_t    pixel_x;
    lr_pkg::coord_t    pixel_y;
    logic              pixel_valid;
    logic              last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_valid, last_pixel,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_valid, last_pixel,
                    output ready);
endinterface

[rtl/lr_setup.sv]
// ----------------------------------------------------------------------------
// Line setup stage
// Clamps endpoints, picks the line mode and start values, and registers them.
// ----------------------------------------------------------------------------
module lr_setup #(
    parameter int CANVAS_SIZE = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    lr_req_if.sink          req,
    input  logic            take,
    output logic            stage_valid,
    output lr_pkg::lr_req_t stage
);

    localparam int          CLAMP_W   = 17;
    localparam logic [CLAMP_W-1:0] CLAMP_TOP = CLAMP_W'(CANVAS_SIZE - 1);

    function automatic lr_pkg::coord_t clamp_coord(input lr_pkg::coord_t v);
        logic [CLAMP_W-1:0] wide;
        wide = CLAMP_W'(v);
        if (wide > CLAMP_TOP)
            return CLAMP_TOP[lr_pkg::COORD_W-1:0];
        return v;
    endfunction

    logic              valid_reg;
    lr_pkg::lr_req_t   stage_reg;
    lr_pkg::lr_req_t   stage_next;
    logic              load;

    lr_pkg::coord_t    xs, ys, xe, ye;
    lr_pkg::coord_t    adx, ady;
    logic              x_ge, y_ge;
    logic [lr_pkg::COORD_W:0] dmin;
    lr_pkg::coord_t    dmaj;
    lr_pkg::err_t      dmin_ext, dmaj_ext;

    assign req.ready = !valid_reg || take;
    assign load      = req.valid && req.ready;

    always_comb
    begin
        xs   = clamp_coord(req.x_start);
        ys   = clamp_coord(req.y_start);
        xe   = clamp_coord(req.x_end);
        ye   = clamp_coord(req.y_end);
        x_ge = xe >= xs;
        y_ge = ye >= ys;
        adx  = x_ge ? xe - xs : xs - xe;
        ady  = y_ge ? ye - ys : ys - ye;
        dmin = '0;
        dmaj = '0;

        stage_next.is_start = (req.operation == lr_pkg::OP_START);
        stage_next.line     = '0;

        priority if (xs == xe)
        begin
            stage_next.line.mode  = lr_pkg::MODE_VERT;
            stage_next.line.minor = xs;
            stage_next.line.major = y_ge ? ys : ye;
            stage_next.line.limit = y_ge ? ye : ys;
        end
        else if (ys == ye)
        begin
            stage_next.line.mode  = lr_pkg::MODE_HORZ;
            stage_next.line.minor = ys;
            stage_next.line.major = x_ge ? xs : xe;
            stage_next.line.limit = x_ge ? xe : xs;
        end
        else if (adx >= ady)
        begin
            stage_next.line.mode = lr_pkg::MODE_XMAJ;
            dmaj                 = adx;
            if (x_ge)
            begin
                stage_next.line.major = xs;
                stage_next.line.minor = ys;
                stage_next.line.limit = xe;
                dmin = {1'b0, ye} - {1'b0, ys};
            end
            else
            begin
                stage_next.line.major = xe;
                stage_next.line.minor = ye;
                stage_next.line.limit = xs;
                dmin = {1'b0, ys} - {1'b0, ye};
            end
        end
        else
        begin
            stage_next.line.mode = lr_pkg::MODE_YMAJ;
            dmaj                 = ady;
            if (!y_ge)
            begin
                stage_next.line.major = ys;
                stage_next.line.minor = xs;
                stage_next.line.limit = ye;
                dmin = {1'b0, xe} - {1'b0, xs};
            end
            else
            begin
                stage_next.line.major = ye;
                stage_next.line.minor = xe;
                stage_next.line.limit = ys;
                dmin = {1'b0, xs} - {1'b0, xe};
            end
        end

        dmin_ext = {dmin[lr_pkg::COORD_W], dmin};
        dmaj_ext = {2'b00, dmaj};
        stage_next.line.inc_stay = dmin_ext;
        stage_next.line.inc_move = dmin[lr_pkg::COORD_W] ? dmin_ext + dmaj_ext
                                                         : dmin_ext - dmaj_ext;
        stage_next.line.err      = stage_next.line.inc_move;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (take)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            stage_reg <= stage_next;
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

[rtl/lr_stepper.sv]
// ----------------------------------------------------------------------------
// Line stepper
// Holds the active line, emits one pixel per request and advances the line.
// ----------------------------------------------------------------------------
module lr_stepper (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            stage_valid,
    input  lr_pkg::lr_req_t stage,
    output logic            take,
    lr_pix_if.source        pix
);

    logic              active_reg, active_next;
    lr_pkg::lr_line_t  line_reg, line_next;
    logic              out_valid_reg;
    lr_pkg::coord_t    px_reg, py_reg, px_next, py_next;
    logic              pv_reg, last_reg, pv_next, last_next;

    lr_pkg::lr_line_t  cur;
    logic              cur_active;
    logic              at_last;
    logic              diag;
    logic              move;

    assign take = stage_valid && (!out_valid_reg || pix.ready);

    always_comb
    begin
        cur        = stage.is_start ? stage.line : line_reg;
        cur_active = stage.is_start || active_reg;
        at_last    = (cur.major == cur.limit);
        diag       = (cur.mode == lr_pkg::MODE_XMAJ) || (cur.mode == lr_pkg::MODE_YMAJ);

        if (cur.inc_stay[lr_pkg::ERR_W-1])
            move = cur.err[lr_pkg::ERR_W-1] || (cur.err == '0);
        else
            move = !cur.err[lr_pkg::ERR_W-1];

        line_next = cur;
        if (diag)
        begin
            line_next.err = cur.err + (move ? cur.inc_move : cur.inc_stay);
            if (move)
                line_next.minor = cur.inc_stay[lr_pkg::ERR_W-1] ? cur.minor - 1'b1
                                                                : cur.minor + 1'b1;
        end
        line_next.major = (cur.mode == lr_pkg::MODE_YMAJ) ? cur.major - 1'b1
                                                          : cur.major + 1'b1;

        active_next = cur_active && !at_last;

        if (cur_active)
        begin
            if ((cur.mode == lr_pkg::MODE_VERT) || (cur.mode == lr_pkg::MODE_YMAJ))
            begin
                px_next = cur.minor;
                py_next = cur.major;
            end
            else
            begin
                px_next = cur.major;
                py_next = cur.minor;
            end
            pv_next   = 1'b1;
            last_next = at_last;
        end
        else
        begin
            px_next   = '0;
            py_next   = '0;
            pv_next   = 1'b0;
            last_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                active_reg    <= active_next;
                out_valid_reg <= 1'b1;
            end
            else if (pix.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            pv_reg   <= pv_next;
            last_reg <= last_next;
            if (cur_active && !at_last)
                line_reg <= line_next;
        end
    end

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_x     = px_reg;
    assign pix.pixel_y     = py_reg;
    assign pix.pixel_valid = pv_reg;
    assign pix.last_pixel  = last_reg;

    a_last_has_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> pv_reg)
        else $error("last pixel flagged on an empty result");

    a_ymaj_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && (line_reg.mode == lr_pkg::MODE_YMAJ) |->
        line_reg.major >= line_reg.limit)
        else $error("y-major line stepped past its end");

    a_other_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && (line_reg.mode != lr_pkg::MODE_YMAJ) |->
        line_reg.major <= line_reg.limit)
        else $error("line stepped past its end");

    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        take && !stage.is_start && !active_reg |=> !pv_reg)
        else $error("step while idle emitted a pixel");

    a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
        take && stage.is_start |=> out_valid_reg && pv_reg)
        else $error("start request emitted no pixel");

endmodule

[rtl/line_rasterizer.sv]
// ----------------------------------------------------------------------------
// Line rasterizer
// Bresenham line drawing over all octants, one pixel per request.
// ----------------------------------------------------------------------------
// A start request latches two endpoints and returns the first pixel; each
// step request returns the next pixel, with last_pixel set on the final one.
// A step with no line in progress returns a result with pixel_valid low.
// Every request gives exactly one result. The block takes one request per
// clock while pix.ready holds the result channel open. A request passes
// the setup register, where endpoints are ordered and the error term is
// seeded, and then the stepper's output register, whose single error-term
// add and end compare set the pixel rate.
module line_rasterizer #(
    parameter int CANVAS_SIZE = 1024
) (
    input  logic     clk,
    input  logic     rst_n,
    lr_req_if.sink   req,
    lr_pix_if.source pix
);

    logic            stage_valid;
    logic            take;
    lr_pkg::lr_req_t stage;

    lr_setup #(
        .CANVAS_SIZE (CANVAS_SIZE)
    ) u_setup (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .take        (take),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    lr_stepper u_stepper (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage       (stage),
        .take        (take),
        .pix         (pix)
    );

endmodule
